>>> hdl/dfr_pkg.sv
package dfr_pkg;

  localparam logic [7:0] PREAMBLE_A = 8'h89;
  localparam logic [7:0] PREAMBLE_B = 8'hFC;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT_A = 3'd0,
    PH_HUNT_B = 3'd1,
    PH_DATA0  = 3'd2,
    PH_DATA1  = 3'd3,
    PH_DATA2  = 3'd4,
    PH_DATA3  = 3'd5,
    PH_CHECK  = 3'd6
  } phase_t;

  // One frame that passed its checksum, already trimmed to the bits in use.
  typedef struct packed {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic       hour_digit;
    logic [7:0] mode_flags;
  } frame_t;

  typedef struct packed {
    logic [3:0] units;
    logic [2:0] tens;
  } digits_t;

  // Splits a value below 64 into decimal digits with a threshold chain.
  function automatic digits_t split_digits(input logic [5:0] value);
    logic [2:0] tens;
    logic [5:0] base;
    digits_t    res;
    if (value >= 6'd60) begin
      tens = 3'd6;
    end else if (value >= 6'd50) begin
      tens = 3'd5;
    end else if (value >= 6'd40) begin
      tens = 3'd4;
    end else if (value >= 6'd30) begin
      tens = 3'd3;
    end else if (value >= 6'd20) begin
      tens = 3'd2;
    end else if (value >= 6'd10) begin
      tens = 3'd1;
    end else begin
      tens = 3'd0;
    end
    base      = 6'({3'd0, tens} * 6'd10);
    res.tens  = tens;
    res.units = 4'(value - base);
    return res;
  endfunction

endpackage

>>> hdl/display_frame_receiver_core.sv
// Display frame receiver. Each input transaction is one received byte or a
// receive timeout; the block hunts for 0x89 then 0xFC, collects seconds,
// minutes, hour and flags bytes, and checks them against a trailing 8-bit
// sum byte. A frame with a matching sum yields one result transaction with
// the seconds and minutes split into decimal digits; a bad frame is dropped
// and a timeout restarts the hunt. One input transaction is taken every
// cycle while in_full is low; a result passes first through the frame
// queue and then the output register. in_full rises only when the frame
// queue (QUEUE_DEPTH entries) is full because results are not being
// popped.
module display_frame_receiver_core import dfr_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_opcode,
  input  logic [7:0] in_rx_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [5:0] out_seconds,
  output logic [5:0] out_minutes,
  output logic [3:0] out_sec_units,
  output logic [2:0] out_sec_tens,
  output logic [3:0] out_min_units,
  output logic [2:0] out_min_tens,
  output logic       out_hour_digit,
  output logic [7:0] out_mode_flags
);

  logic   in_accept;
  logic   frm_push;
  frame_t frm_data;
  logic   q_full, q_empty, q_pop;
  frame_t q_data;

  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  dfr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .opcode   (in_opcode),
    .rx_byte  (in_rx_byte),
    .frm_push (frm_push),
    .frm_data (frm_data)
  );

  dfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (frm_push),
    .wr_data (frm_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  dfr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_seconds    (out_seconds),
    .out_minutes    (out_minutes),
    .out_sec_units  (out_sec_units),
    .out_sec_tens   (out_sec_tens),
    .out_min_units  (out_min_units),
    .out_min_tens   (out_min_tens),
    .out_hour_digit (out_hour_digit),
    .out_mode_flags (out_mode_flags)
  );

endmodule

>>> hdl/dfr_front.sv
module dfr_front import dfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       opcode,
  input  logic [7:0] rx_byte,
  output logic       frm_push,
  output frame_t     frm_data
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [5:0] sec_r, min_r;
  logic       hour_r;
  logic [7:0] flags_r;
  logic       is_byte;

  assign is_byte = accept && (opcode == OP_BYTE);

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (opcode == OP_TIMEOUT) begin
        phase_nxt = PH_HUNT_A;
      end else begin
        case (phase_r)
          PH_HUNT_B: begin
            if (rx_byte == PREAMBLE_B) phase_nxt = PH_DATA0;
          end
          PH_DATA0: phase_nxt = PH_DATA1;
          PH_DATA1: phase_nxt = PH_DATA2;
          PH_DATA2: phase_nxt = PH_DATA3;
          PH_DATA3: phase_nxt = PH_CHECK;
          PH_CHECK: phase_nxt = PH_HUNT_A;
          default: begin
            phase_nxt = (rx_byte == PREAMBLE_A) ? PH_HUNT_B : PH_HUNT_A;
          end
        endcase
      end
    end
  end

  always_comb begin
    sum_nxt  = sum_r;
    frm_push = 1'b0;
    if (accept) begin
      if (opcode == OP_TIMEOUT) begin
        sum_nxt = 8'd0;
      end else begin
        case (phase_r)
          PH_HUNT_B: begin
            if (rx_byte == PREAMBLE_B) sum_nxt = 8'd0;
          end
          PH_DATA0, PH_DATA1, PH_DATA2, PH_DATA3: sum_nxt = sum_r + rx_byte;
          PH_CHECK: begin
            sum_nxt  = 8'd0;
            frm_push = (rx_byte == sum_r);
          end
          default: sum_nxt = sum_r;
        endcase
      end
    end
  end

  assign frm_data.seconds    = sec_r;
  assign frm_data.minutes    = min_r;
  assign frm_data.hour_digit = hour_r;
  assign frm_data.mode_flags = flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT_A;
      sum_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Only the bits that reach the result are kept for each data byte.
  always_ff @(posedge clk) begin
    if (is_byte && phase_r == PH_DATA0) sec_r   <= rx_byte[5:0];
    if (is_byte && phase_r == PH_DATA1) min_r   <= rx_byte[5:0];
    if (is_byte && phase_r == PH_DATA2) hour_r  <= rx_byte[0];
    if (is_byte && phase_r == PH_DATA3) flags_r <= rx_byte;
  end

  a_timeout_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && opcode == OP_TIMEOUT |=> phase_r == PH_HUNT_A)
    else $error("timeout did not return to preamble hunt");

  a_push_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    frm_push |=> phase_r == PH_HUNT_A && sum_r == 8'd0)
    else $error("frame push did not restart the hunt");

endmodule

>>> hdl/dfr_queue.sv
module dfr_queue import dfr_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  frame_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output logic   empty,
  output frame_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  frame_t          slots_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (rd_en) rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots_r[wr_ptr_r] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full))
    else $error("write into a full frame queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && empty))
    else $error("read from an empty frame queue");

endmodule

>>> hdl/dfr_back.sv
module dfr_back import dfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  frame_t     q_data,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [5:0] out_seconds,
  output logic [5:0] out_minutes,
  output logic [3:0] out_sec_units,
  output logic [2:0] out_sec_tens,
  output logic [3:0] out_min_units,
  output logic [2:0] out_min_tens,
  output logic       out_hour_digit,
  output logic [7:0] out_mode_flags
);

  logic    valid_r, valid_nxt;
  digits_t sec_dig, min_dig;
  frame_t  frame_r;
  digits_t sec_dig_r, min_dig_r;

  assign sec_dig = split_digits(q_data.seconds);
  assign min_dig = split_digits(q_data.minutes);

  // The output register refills in the same cycle that its transaction completes.
  assign q_pop = !q_empty && (!valid_r || out_pop);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame_r   <= q_data;
      sec_dig_r <= sec_dig;
      min_dig_r <= min_dig;
    end
  end

  assign out_empty      = !valid_r;
  assign out_seconds    = frame_r.seconds;
  assign out_minutes    = frame_r.minutes;
  assign out_sec_units  = sec_dig_r.units;
  assign out_sec_tens   = sec_dig_r.tens;
  assign out_min_units  = min_dig_r.units;
  assign out_min_tens   = min_dig_r.tens;
  assign out_hour_digit = frame_r.hour_digit;
  assign out_mode_flags = frame_r.mode_flags;

  a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !out_empty)
    else $error("queue pop did not load the output register");

  a_digits_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_sec_units < 4'd10 && out_min_units < 4'd10)
    else $error("decimal digit out of range");

endmodule

>>> test/display_frame_receiver_checker.sv
`timescale 1ns / 1ps

module display_frame_receiver_checker
  import dfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  logic       in_opcode,
  input  logic [7:0] in_rx_byte,
  input  logic       out_empty,
  input  logic       out_pop,
  input  logic [5:0] out_seconds,
  input  logic [5:0] out_minutes,
  input  logic [3:0] out_sec_units,
  input  logic [2:0] out_sec_tens,
  input  logic [3:0] out_min_units,
  input  logic [2:0] out_min_tens,
  input  logic       out_hour_digit,
  input  logic [7:0] out_mode_flags,
  output int         fail_count,
  output int         frames_pending
);

  typedef struct {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [3:0] sec_units;
    logic [2:0] sec_tens;
    logic [3:0] min_units;
    logic [2:0] min_tens;
    logic       hour_digit;
    logic [7:0] mode_flags;
  } readout_t;

  readout_t   expected_frames[$];
  phase_t     rx_phase;
  logic [7:0] frame_data[4];
  logic [7:0] frame_sum;
  int         errors = 0;

  // Advances the frame parser by one transaction and queues a readout when a
  // frame closes with a matching sum.
  task automatic track_byte(input logic op, input logic [7:0] rx);
    readout_t   ro;
    logic [5:0] sec;
    logic [5:0] mins;
    if (op == OP_TIMEOUT) begin
      rx_phase  = PH_HUNT_A;
      frame_sum = '0;
    end else begin
      case (rx_phase)
        PH_HUNT_B: begin
          if (rx == PREAMBLE_B) begin
            frame_sum = '0;
            rx_phase  = PH_DATA0;
          end
        end
        PH_DATA0, PH_DATA1, PH_DATA2, PH_DATA3: begin
          frame_data[int'(rx_phase) - int'(PH_DATA0)] = rx;
          frame_sum = frame_sum + rx;
          rx_phase  = phase_t'(rx_phase + 3'd1);
        end
        PH_CHECK: begin
          if (rx == frame_sum) begin
            sec           = frame_data[0][5:0];
            mins          = frame_data[1][5:0];
            ro.seconds    = sec;
            ro.minutes    = mins;
            ro.sec_units  = 4'(sec % 6'd10);
            ro.sec_tens   = 3'(sec / 6'd10);
            ro.min_units  = 4'(mins % 6'd10);
            ro.min_tens   = 3'(mins / 6'd10);
            ro.hour_digit = frame_data[2][0];
            ro.mode_flags = frame_data[3];
            expected_frames.push_back(ro);
          end
          rx_phase  = PH_HUNT_A;
          frame_sum = '0;
        end
        default: begin
          rx_phase = (rx == PREAMBLE_A) ? PH_HUNT_B : PH_HUNT_A;
        end
      endcase
    end
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    readout_t ro;
    if (!rst_n) begin
      rx_phase  = PH_HUNT_A;
      frame_sum = '0;
      expected_frames.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_frames.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: readout with nothing expected, seconds %0d minutes %0d flags %0h",
                     $realtime, out_seconds, out_minutes, out_mode_flags);
          end
        end else begin
          ro = expected_frames.pop_front();
          compare_field("seconds", ro.seconds, out_seconds);
          compare_field("minutes", ro.minutes, out_minutes);
          compare_field("sec_units", ro.sec_units, out_sec_units);
          compare_field("sec_tens", ro.sec_tens, out_sec_tens);
          compare_field("min_units", ro.min_units, out_min_units);
          compare_field("min_tens", ro.min_tens, out_min_tens);
          compare_field("hour_digit", ro.hour_digit, out_hour_digit);
          compare_field("mode_flags", ro.mode_flags, out_mode_flags);
        end
      end
      if (in_push && !in_full) begin
        track_byte(in_opcode, in_rx_byte);
      end
    end
    fail_count     <= errors;
    frames_pending <= expected_frames.size();
  end

endmodule

>>> test/tb_display_frame_receiver_core.sv
`timescale 1ns / 1ps

module tb_display_frame_receiver_core;
  import dfr_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic       op;
    logic [7:0] rx;
  } rx_event_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic       in_opcode;
  logic [7:0] in_rx_byte;
  logic       out_empty;
  logic       out_pop;
  logic [5:0] out_seconds;
  logic [5:0] out_minutes;
  logic [3:0] out_sec_units;
  logic [2:0] out_sec_tens;
  logic [3:0] out_min_units;
  logic [2:0] out_min_tens;
  logic       out_hour_digit;
  logic [7:0] out_mode_flags;
  int         fail_count;
  int         frames_pending;

  rx_event_t  rx_events[$];
  int         bytes_taken = 0;
  int         stall_cycles = 0;

  always #4 clk = ~clk;

  display_frame_receiver_core DUT (.*);

  display_frame_receiver_checker checker_i (.*);

  task automatic add_event(input logic op, input logic [7:0] rx);
    rx_event_t ev;
    ev.op = op;
    ev.rx = rx;
    rx_events.push_back(ev);
  endtask

  task automatic add_frame(input logic [7:0] sec_b, input logic [7:0] min_b,
                           input logic [7:0] hour_b, input logic [7:0] flag_b,
                           input logic [7:0] check_b);
    add_event(OP_BYTE, PREAMBLE_A);
    add_event(OP_BYTE, PREAMBLE_B);
    add_event(OP_BYTE, sec_b);
    add_event(OP_BYTE, min_b);
    add_event(OP_BYTE, hour_b);
    add_event(OP_BYTE, flag_b);
    add_event(OP_BYTE, check_b);
  endtask

  // Mostly well-formed frames with random content; the rest are frames cut
  // short by a timeout, bad sums and plain line noise.
  task automatic build_random_traffic(input int frame_bytes_wanted);
    logic [7:0] frame[7];
    int         useful;
    int         roll;
    int         cut;
    useful = 0;
    while (useful < frame_bytes_wanted) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        repeat ($urandom_range(1, 4)) begin
          add_event(($urandom_range(99) < 20) ? OP_TIMEOUT : OP_BYTE, 8'($urandom));
        end
      end else begin
        frame[0] = PREAMBLE_A;
        frame[1] = PREAMBLE_B;
        frame[2] = $urandom_range(1) ? 8'($urandom_range(59)) : 8'($urandom);
        frame[3] = $urandom_range(1) ? 8'($urandom_range(59)) : 8'($urandom);
        frame[4] = 8'($urandom);
        frame[5] = 8'($urandom);
        frame[6] = frame[2] + frame[3] + frame[4] + frame[5];
        if ($urandom_range(99) < 15) begin
          frame[6] = frame[6] + 8'($urandom_range(1, 255));
        end
        cut = (roll < 30) ? $urandom_range(0, 6) : 7;
        for (int i = 0; i < 7; i++) begin
          if (i == cut) begin
            add_event(OP_TIMEOUT, 8'($urandom));
            break;
          end
          add_event(OP_BYTE, frame[i]);
          useful++;
          // Stray bytes between the two preamble bytes are skipped.
          if (i == 0 && $urandom_range(9) == 0) begin
            add_event(OP_BYTE, 8'($urandom));
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      bytes_taken <= bytes_taken + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random pops, one long hold-off to back the block up, and a
  // calm window in which every result is taken at once.
  initial begin
    int  hold;
    bit  held;
    hold = 0;
    held = 1'b0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && bytes_taken >= 300) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_pop <= 1'b0;
      end else if (bytes_taken >= 600 && bytes_taken < 800) begin
        out_pop <= 1'b1;
      end else begin
        out_pop <= ($urandom_range(99) >= 37);
      end
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_push    <= 1'b0;
    in_opcode  <= OP_BYTE;
    in_rx_byte <= '0;

    // Timeout while hunting, then a good all-zero frame behind a repeated
    // first preamble byte.
    add_event(OP_TIMEOUT, 8'hFF);
    add_event(OP_BYTE, PREAMBLE_A);
    add_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    // All ones: the sum wraps around to 0xFC.
    add_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFC);
    // Bad sum, dropped silently.
    add_frame(8'h3B, 8'h3B, 8'h01, 8'h5A, 8'h00);
    // Timeout while waiting for the second preamble byte.
    add_event(OP_BYTE, PREAMBLE_A);
    add_event(OP_TIMEOUT, 8'h00);
    build_random_traffic(1000);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rx_events[i]) begin
      if (!(i >= 600 && i < 800) && $urandom_range(99) < 37) begin
        in_push <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < 37);
      end
      in_push    <= 1'b1;
      in_opcode  <= rx_events[i].op;
      in_rx_byte <= rx_events[i].rx;
      @(posedge clk);
      while (in_full) @(posedge clk);
    end
    in_push <= 1'b0;

    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (fail_count == 0 && frames_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
